### rtl/udp_echo_responder_core_defines.svh
// ----------------------------------------------------------------------------
// UDP echo responder assertion macros
// Wrappers for concurrent checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef UDP_ECHO_RESPONDER_CORE_DEFINES_SVH
`define UDP_ECHO_RESPONDER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define UER_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uer assertion failed");
// next-cycle implication
`define UER_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uer assertion failed");
`else
`define UER_ASSERT_IMP(lbl, ante, cons)
`define UER_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// UDP echo responder package
// Shared word type, protocol constants and byte helpers.
// ----------------------------------------------------------------------------
package uer_pkg;

	typedef logic [63:0] word_t;

	localparam logic [7:0]  ETYPE_HI  = 8'h08;
	localparam logic [7:0]  ETYPE_LO  = 8'h00;
	localparam logic [7:0]  IP_VIHL   = 8'h45;
	localparam logic [7:0]  IP_TOS    = 8'h00;
	localparam logic [7:0]  IP_TTL    = 8'd64;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [15:0] IP_HDR_LEN = 16'd20;
	localparam logic [16:0] ETH_IP_LEN = 17'd34;
	localparam logic [15:0] UDP_HDR_LEN = 16'd8;
	localparam int          HDR_BYTES = 42;
	localparam int          HDR_WORDS = 5;   // words 0..4 rebuilt from registers
	localparam int          CK_WORD   = 5;   // word holding the UDP checksum

	// keep the first n bytes (from the top), zero the rest
	function automatic word_t keep_bytes(input word_t d, input logic [3:0] n);
		word_t r;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			if (4'(k) < n) begin
				r[63 - 8 * k -: 8] = d[63 - 8 * k -: 8];
			end
		end
		return r;
	endfunction

	// ones-complement fold of a 32-bit sum
	function automatic logic [15:0] fold32(input logic [31:0] a);
		logic [16:0] s;
		logic [16:0] t;
		s = {1'b0, a[15:0]} + {1'b0, a[31:16]};
		t = {1'b0, s[15:0]} + {16'd0, s[16]};
		return t[15:0];
	endfunction

endpackage

### rtl/uer_frame_store.sv
// ----------------------------------------------------------------------------
// UDP echo responder frame store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module uer_frame_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  uer_pkg::word_t wr_data,
	input  logic [AW-1:0]  rd_addr,
	output uer_pkg::word_t rd_data
);
	import uer_pkg::*;

	word_t mem [DEPTH];
	word_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

### rtl/udp_echo_responder_core.sv
// ----------------------------------------------------------------------------
// UDP echo responder core
// Buffers a received frame and echoes a UDP frame back with swapped addresses.
// ----------------------------------------------------------------------------
// Frame words are taken one per cycle while idle and written into the frame
// store. The first five words are also kept in registers for the header
// fields. After the last word the block stalls its input: a header check,
// then a checksum pass that reads the payload words from the store (a store
// read, then an accumulate step per word), a step to finish both checksums,
// and the reply, again with a store read and an output load per word; the
// load waits while the output stalls. A frame that fails the header check is
// dropped and the block returns to idle. The output register lets the last
// reply word wait while the next frame comes in.
module udp_echo_responder_core #(
	parameter int MAX_FRAME_WORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] in_data,
	input  logic [3:0]  in_bytes,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_data,
	output logic [3:0]  out_bytes,
	output logic        out_last
);
	import uer_pkg::*;
`include "udp_echo_responder_core_defines.svh"

	localparam int AW  = $clog2(MAX_FRAME_WORDS);
	localparam int WIW = $clog2(MAX_FRAME_WORDS + 1);
	localparam int CBW = WIW + 3;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CHECK   = 3'd1;
	localparam logic [2:0] ST_SUM_RD  = 3'd2;
	localparam logic [2:0] ST_SUM_ACC = 3'd3;
	localparam logic [2:0] ST_FIN     = 3'd4;
	localparam logic [2:0] ST_EMIT_RD = 3'd5;
	localparam logic [2:0] ST_EMIT_LD = 3'd6;

	logic [2:0]     state_q;
	logic [WIW-1:0] widx_q;
	logic [CBW-1:0] cap_q;
	logic           ovf_q;
	word_t          hw_q [HDR_WORDS];
	logic [CBW-1:0] total_q;
	logic [WIW-1:0] nwords_q;
	logic [WIW-1:0] idx_q;
	logic [31:0]    acc_q;
	logic [15:0]    udp_ck_q;
	logic [15:0]    ip_ck_q;
	logic           out_valid_q;
	word_t          out_data_q;
	logic [3:0]     out_bytes_q;
	logic           out_last_q;

	// input side
	logic           in_acc;
	logic [3:0]     cnt_sat;
	word_t          din;
	logic           room;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign cnt_sat  = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
	assign din      = keep_bytes(in_data, cnt_sat);
	assign room     = (widx_q < WIW'(MAX_FRAME_WORDS));

	// header bytes of the received frame
	logic [319:0] hdr;
	assign hdr = {hw_q[0], hw_q[1], hw_q[2], hw_q[3], hw_q[4]};

	function automatic logic [7:0] rxb(input logic [319:0] h, input int p);
		return h[319 - 8 * p -: 8];
	endfunction

	logic [15:0] udplen;
	logic [16:0] total17;
	logic        frame_ok;
	logic [CBW:0] t7;
	logic [CBW-2:0] nw_full;

	assign udplen   = {rxb(hdr, 38), rxb(hdr, 39)};
	assign total17  = ETH_IP_LEN + {1'b0, udplen};
	assign frame_ok = !ovf_q && (cap_q >= CBW'(HDR_BYTES))
		&& (rxb(hdr, 12) == ETYPE_HI) && (rxb(hdr, 13) == ETYPE_LO)
		&& (rxb(hdr, 23) == PROTO_UDP) && (udplen >= UDP_HDR_LEN)
		&& (total17 <= 17'(cap_q));
	assign t7      = {1'b0, total17[CBW-1:0]} + (CBW+1)'(7);
	assign nw_full = t7[CBW:3];

	// 16-bit words of the swapped addresses and ports
	logic [15:0] ipa0, ipa1, ipa2, ipa3, prt0, prt1;
	assign ipa0 = {rxb(hdr, 26), rxb(hdr, 27)};
	assign ipa1 = {rxb(hdr, 28), rxb(hdr, 29)};
	assign ipa2 = {rxb(hdr, 30), rxb(hdr, 31)};
	assign ipa3 = {rxb(hdr, 32), rxb(hdr, 33)};
	assign prt0 = {rxb(hdr, 34), rxb(hdr, 35)};
	assign prt1 = {rxb(hdr, 36), rxb(hdr, 37)};

	logic [31:0] acc_init;
	assign acc_init = 32'(ipa0) + 32'(ipa1) + 32'(ipa2) + 32'(ipa3) + 32'(PROTO_UDP)
		+ 32'(udplen) + 32'(udplen) + 32'(prt0) + 32'(prt1);

	logic [15:0] iplen;
	logic [31:0] ip_sum;
	logic [15:0] udp_fold;
	assign iplen    = IP_HDR_LEN + udplen;
	assign ip_sum   = 32'({IP_VIHL, IP_TOS}) + 32'(iplen) + 32'({IP_TTL, PROTO_UDP})
		+ 32'(ipa0) + 32'(ipa1) + 32'(ipa2) + 32'(ipa3);
	assign udp_fold = ~fold32(acc_q);

	// frame store
	word_t          rd_data;
	logic [AW-1:0]  rd_addr;
	assign rd_addr = idx_q[AW-1:0];

	uer_frame_store #(
		.DEPTH(MAX_FRAME_WORDS),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (in_acc && room),
		.wr_addr(widx_q[AW-1:0]),
		.wr_data(din),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// bytes of the current word that lie inside the reply
	logic [CBW-1:0] rem;
	logic [3:0]     nkeep;
	logic           is_last_word;
	assign rem          = total_q - {idx_q, 3'b000};
	assign nkeep        = (rem >= CBW'(8)) ? 4'd8 : rem[3:0];
	assign is_last_word = (idx_q + WIW'(1) == nwords_q);

	// checksum pass: payload lanes, checksum field excluded
	word_t       sw;
	logic [31:0] lane_sum;
	always_comb begin
		sw = keep_bytes(rd_data, nkeep);
		if (idx_q == WIW'(CK_WORD)) begin
			sw[63:48] = 16'd0;
		end
		lane_sum = 32'(sw[63:48]) + 32'(sw[47:32]) + 32'(sw[31:16]) + 32'(sw[15:0]);
	end

	// reply word assembly
	word_t ew;
	always_comb begin
		case (idx_q)
			WIW'(0): ew = {rxb(hdr, 6), rxb(hdr, 7), rxb(hdr, 8), rxb(hdr, 9),
				rxb(hdr, 10), rxb(hdr, 11), rxb(hdr, 0), rxb(hdr, 1)};
			WIW'(1): ew = {rxb(hdr, 2), rxb(hdr, 3), rxb(hdr, 4), rxb(hdr, 5),
				ETYPE_HI, ETYPE_LO, IP_VIHL, IP_TOS};
			WIW'(2): ew = {iplen, 32'd0, IP_TTL, PROTO_UDP};
			WIW'(3): ew = {ip_ck_q, ipa2, ipa3, ipa0};
			WIW'(4): ew = {ipa1, prt1, prt0, udplen};
			WIW'(CK_WORD): ew = {udp_ck_q, rd_data[47:0]};
			default: ew = rd_data;
		endcase
	end

	logic out_load;
	assign out_load = (state_q == ST_EMIT_LD) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			widx_q      <= '0;
			cap_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a new word or retire the accepted one
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (room) begin
							widx_q <= widx_q + WIW'(1);
							cap_q  <= {widx_q, 3'b000} + CBW'(cnt_sat);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (frame_ok) begin
						state_q <= ST_SUM_RD;
					end else begin
						state_q <= ST_IDLE;
						widx_q  <= '0;
						cap_q   <= '0;
						ovf_q   <= 1'b0;
					end
				end
				ST_SUM_RD: state_q <= ST_SUM_ACC;
				ST_SUM_ACC: state_q <= is_last_word ? ST_FIN : ST_SUM_RD;
				ST_FIN: state_q <= ST_EMIT_RD;
				ST_EMIT_RD: state_q <= ST_EMIT_LD;
				ST_EMIT_LD: begin
					if (out_load) begin
						if (is_last_word) begin
							state_q <= ST_IDLE;
							widx_q  <= '0;
							cap_q   <= '0;
							ovf_q   <= 1'b0;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc && room && (widx_q < WIW'(HDR_WORDS))) begin
			hw_q[widx_q[2:0]] <= din;
		end
		case (state_q)
			ST_CHECK: begin
				total_q  <= total17[CBW-1:0];
				nwords_q <= nw_full[WIW-1:0];
				acc_q    <= acc_init;
				idx_q    <= WIW'(CK_WORD);
			end
			ST_SUM_ACC: begin
				acc_q <= acc_q + lane_sum;
				idx_q <= idx_q + WIW'(1);
			end
			ST_FIN: begin
				udp_ck_q <= (udp_fold == 16'd0) ? 16'hFFFF : udp_fold;
				ip_ck_q  <= ~fold32(ip_sum);
				idx_q    <= '0;
			end
			ST_EMIT_LD: begin
				if (out_load) begin
					out_data_q  <= keep_bytes(ew, nkeep);
					out_bytes_q <= is_last_word ? nkeep : 4'd8;
					out_last_q  <= is_last_word;
					idx_q       <= idx_q + WIW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_bytes = out_bytes_q;
	assign out_last  = out_last_q;

	`UER_ASSERT_NXT(a_last_to_check, in_acc && in_last, state_q == ST_CHECK)
	`UER_ASSERT_IMP(a_idx_in_range, state_q == ST_SUM_ACC || state_q == ST_EMIT_LD,
		idx_q < nwords_q)
	`UER_ASSERT_NXT(a_reply_end_clears, out_load && is_last_word,
		state_q == ST_IDLE && widx_q == '0 && out_valid_q && out_last_q)

endmodule
